// ===== src/tstg_pkg.sv =====
// shared constants and the sine table generator for the timed sine tone generator
package tstg_pkg;

    localparam int FREQ_W   = 16;
    localparam int DUR_W    = 16;
    localparam int AMP_W    = 15;
    localparam int RATE_W   = 18;
    localparam int PCM_W    = 16;
    localparam int FRAMES_W = 24;
    localparam int SINE_W   = 15;

    // multiplier bits walked by the bit-serial multiply (duration or amplitude)
    localparam int MUL_STEPS = DUR_W;

    localparam logic [RATE_W-1:0]   RATE_RESET = 18'd16000;
    localparam logic [RATE_W-1:0]   MS_PER_S   = 18'd1000;
    localparam logic [AMP_W-1:0]    AMP_LIMIT  = 15'd31130;
    localparam logic [FRAMES_W-1:0] FRAMES_MAX = 24'hFFFFFF;

    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

    // request kinds carried in the mode field
    typedef enum logic {
        MODE_START = 1'b0,
        MODE_TICK  = 1'b1
    } t_mode;

    // one quarter-wave entry: Q30 taylor series of sin, rounded to Q0.15, capped
    function automatic logic [SINE_W-1:0] sine_entry(input int unsigned idx,
                                                     input int unsigned abits);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint unsigned sum;
        longint unsigned v;
        x    = (HALF_PI_Q30 * longint'(idx)) >> abits;
        x2   = (x * x) >> 30;
        term = x;
        sum  = x;
        term = ((term * x2) >> 30) / 64'd6;
        sum  = (sum > term) ? sum - term : 64'd0;
        term = ((term * x2) >> 30) / 64'd20;
        sum  = sum + term;
        term = ((term * x2) >> 30) / 64'd42;
        sum  = (sum > term) ? sum - term : 64'd0;
        term = ((term * x2) >> 30) / 64'd72;
        sum  = sum + term;
        term = ((term * x2) >> 30) / 64'd110;
        sum  = (sum > term) ? sum - term : 64'd0;
        term = ((term * x2) >> 30) / 64'd156;
        sum  = sum + term;
        v = (sum * 64'd32767 + (64'd1 << 29)) >> 30;
        if (v > 64'd32767) begin
            v = 64'd32767;
        end
        return v[SINE_W-1:0];
    endfunction

endpackage

// ===== src/tstg_in_if.sv =====
// request channel: start command or sample tick
interface tstg_in_if;
    logic                          valid;
    logic                          ready;
    logic                          mode;
    logic [tstg_pkg::FREQ_W-1:0]   tone_freq_hz;
    logic [tstg_pkg::DUR_W-1:0]    tone_duration_ms;
    logic [tstg_pkg::AMP_W-1:0]    amplitude_q15;

    modport source (
        output valid, mode, tone_freq_hz, tone_duration_ms, amplitude_q15,
        input  ready
    );
    modport sink (
        input  valid, mode, tone_freq_hz, tone_duration_ms, amplitude_q15,
        output ready
    );
endinterface

// ===== src/tstg_out_if.sv =====
// result channel: start status or one pcm frame
interface tstg_out_if;
    logic                               valid;
    logic                               ready;
    logic                               start_accepted;
    logic                               frame_valid;
    logic signed [tstg_pkg::PCM_W-1:0]  pcm_sample;
    logic                               last_frame;

    modport source (
        output valid, start_accepted, frame_valid, pcm_sample, last_frame,
        input  ready
    );
    modport sink (
        input  valid, start_accepted, frame_valid, pcm_sample, last_frame,
        output ready
    );
endinterface

// ===== src/tstg_sine_rom.sv =====
// quarter-wave sine rom, contents fixed at elaboration, registered read
module tstg_sine_rom #(
    parameter int SINE_TABLE_DEPTH = 1024
) (
    input  logic                                 i_clk,
    input  logic [$clog2(SINE_TABLE_DEPTH):0]    i_addr,
    output logic [tstg_pkg::SINE_W-1:0]          o_data
);
    localparam int ABITS = $clog2(SINE_TABLE_DEPTH);

    logic [tstg_pkg::SINE_W-1:0] w_rom [0:SINE_TABLE_DEPTH];
    logic [tstg_pkg::SINE_W-1:0] r_data;

    for (genvar g = 0; g <= SINE_TABLE_DEPTH; g++) begin : g_entry
        assign w_rom[g] = tstg_pkg::sine_entry(g, ABITS);
    end

    always_ff @(posedge i_clk) begin
        r_data <= w_rom[i_addr];
    end

    assign o_data = r_data;
endmodule

// ===== src/timed_sine_tone_generator_top.sv =====
// Timed sine tone generator: a start request loads a tone (phase step
// freq*2^PHASE_BITS/rate, frame count rate*duration_ms/1000 saturated to 2^24-1,
// amplitude clamped to 31130) and every tick request while frames remain returns
// one pcm frame from a quarter-wave table scaled by the amplitude. One request
// is handled at a time. All arithmetic runs through one shared bit-serial unit:
// a restoring divider with an 18-bit remainder and a shift-add multiplier over
// a work register of max(PHASE_BITS+16, 34) bits. An accepted start runs the
// step divide, the 16 multiply steps and the divide by 1000; a tick that makes
// a frame runs a rom read and the 16 multiply steps; a refused start or an idle
// tick goes straight to emit. The sine table is a rom of SINE_TABLE_DEPTH+1
// entries (a power of two, at most 2^(PHASE_BITS-2)). A finished result sits in
// an output register until it is taken; the next request is accepted meanwhile.
module timed_sine_tone_generator_top #(
    parameter int PHASE_BITS       = 32,
    parameter int SINE_TABLE_DEPTH = 1024
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    tstg_in_if.sink                       i_req,
    tstg_out_if.source                    o_rsp,
    input  logic                          i_cfg_we,
    input  logic [tstg_pkg::RATE_W-1:0]   i_cfg_wdata
);
    localparam int ABITS     = $clog2(SINE_TABLE_DEPTH);
    localparam int QBITS     = PHASE_BITS - 2;
    localparam int WORK_BITS = (PHASE_BITS + tstg_pkg::FREQ_W > 34) ?
                               PHASE_BITS + tstg_pkg::FREQ_W : 34;
    localparam int CNT_BITS  = $clog2(WORK_BITS);
    localparam int RW        = tstg_pkg::RATE_W;

    localparam logic [ABITS:0]    DEPTH_A   = (ABITS + 1)'(SINE_TABLE_DEPTH);
    localparam logic [CNT_BITS-1:0] DIV_LAST = CNT_BITS'(WORK_BITS - 1);
    localparam logic [CNT_BITS-1:0] MUL_LAST = CNT_BITS'(tstg_pkg::MUL_STEPS - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_STEP_DIV,
        S_MUL,
        S_ROM,
        S_FDIV,
        S_EMIT
    } t_state;

    t_state                          r_state;
    logic [RW-1:0]                   r_rate;
    logic [PHASE_BITS-1:0]           r_phase;
    logic [PHASE_BITS-1:0]           r_phase_inc;
    logic [tstg_pkg::FRAMES_W-1:0]   r_frames_left;
    logic [tstg_pkg::AMP_W-1:0]      r_amp;

    logic [WORK_BITS-1:0]            r_work;
    logic [RW-1:0]                   r_rem;
    logic [RW-1:0]                   r_dvs;
    logic [tstg_pkg::DUR_W-1:0]      r_mplr;
    logic [CNT_BITS-1:0]             r_cnt;
    logic                            r_is_tick;
    logic                            r_neg;
    logic [ABITS:0]                  r_addr;

    logic                            r_res_acc;
    logic                            r_res_fv;
    logic [tstg_pkg::PCM_W-1:0]      r_res_pcm;
    logic                            r_res_last;

    logic                            r_o_valid;
    logic                            r_o_acc;
    logic                            r_o_fv;
    logic [tstg_pkg::PCM_W-1:0]      r_o_pcm;
    logic                            r_o_last;

    logic                            w_accept;
    logic                            w_slot_free;
    logic [tstg_pkg::SINE_W-1:0]     w_sine;
    logic [ABITS:0]                  w_a;
    logic [ABITS:0]                  w_addr;
    logic [RW:0]                     w_rem_sh;
    logic                            w_ge;
    logic [RW-1:0]                   n_rem;
    logic [WORK_BITS-1:0]            n_div_work;
    logic [RW-1:0]                   w_addend;
    logic [WORK_BITS-1:0]            n_mul_work;
    logic [tstg_pkg::PCM_W-1:0]      n_prod;
    logic [tstg_pkg::PCM_W-1:0]      n_pcm;
    logic [tstg_pkg::FRAMES_W-1:0]   n_frames;
    logic [tstg_pkg::AMP_W-1:0]      n_amp;

    tstg_sine_rom #(
        .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
    ) u_rom (
        .i_clk  (i_clk),
        .i_addr (r_addr),
        .o_data (w_sine)
    );

    always_comb begin
        w_accept    = i_req.valid && (r_state == S_IDLE);
        w_slot_free = !r_o_valid || o_rsp.ready;

        // quadrant 1 and 3 read the table backwards
        w_a    = {1'b0, r_phase[QBITS-1 -: ABITS]};
        w_addr = r_phase[PHASE_BITS-2] ? (DEPTH_A - w_a) : w_a;

        // restoring divide step
        w_rem_sh   = {r_rem, r_work[WORK_BITS-1]};
        w_ge       = (w_rem_sh >= {1'b0, r_dvs});
        n_rem      = w_ge ? RW'(w_rem_sh - {1'b0, r_dvs}) : w_rem_sh[RW-1:0];
        n_div_work = {r_work[WORK_BITS-2:0], w_ge};

        // shift-add multiply step, msb of the multiplier first
        w_addend   = r_is_tick ? RW'(w_sine) : r_dvs;
        n_mul_work = {r_work[WORK_BITS-2:0], 1'b0} +
                     (r_mplr[tstg_pkg::DUR_W-1] ? WORK_BITS'(w_addend) : '0);

        n_prod = {1'b0, n_mul_work[29:15]};
        n_pcm  = r_neg ? (~n_prod + 16'd1) : n_prod;

        n_frames = (|n_div_work[WORK_BITS-1:tstg_pkg::FRAMES_W]) ? tstg_pkg::FRAMES_MAX :
                   n_div_work[tstg_pkg::FRAMES_W-1:0];

        n_amp = (i_req.amplitude_q15 > tstg_pkg::AMP_LIMIT) ? tstg_pkg::AMP_LIMIT :
                i_req.amplitude_q15;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_rate        <= tstg_pkg::RATE_RESET;
            r_phase       <= '0;
            r_phase_inc   <= '0;
            r_frames_left <= '0;
            r_amp         <= '0;
            r_o_valid     <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_rate <= i_cfg_wdata;
            end
            // a result loaded in the emit state keeps the output valid
            if (r_o_valid && o_rsp.ready && r_state != S_EMIT) begin
                r_o_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_res_acc  <= 1'b0;
                        r_res_fv   <= 1'b0;
                        r_res_pcm  <= '0;
                        if (i_req.mode == tstg_pkg::MODE_START) begin
                            r_res_last <= 1'b0;
                            if (i_req.tone_freq_hz == '0 || i_req.tone_duration_ms == '0) begin
                                r_state <= S_EMIT;
                            end else begin
                                r_amp     <= n_amp;
                                r_phase   <= '0;
                                r_work    <= WORK_BITS'(i_req.tone_freq_hz) << PHASE_BITS;
                                r_rem     <= '0;
                                r_dvs     <= r_rate;
                                r_mplr    <= i_req.tone_duration_ms;
                                r_is_tick <= 1'b0;
                                r_cnt     <= DIV_LAST;
                                r_state   <= S_STEP_DIV;
                            end
                        end else if (r_frames_left == '0) begin
                            r_res_last <= 1'b0;
                            r_state    <= S_EMIT;
                        end else begin
                            r_addr        <= w_addr;
                            r_neg         <= r_phase[PHASE_BITS-1];
                            r_res_last    <= (r_frames_left == 24'd1);
                            r_frames_left <= r_frames_left - 24'd1;
                            r_phase       <= r_phase + r_phase_inc;
                            r_mplr        <= tstg_pkg::DUR_W'(r_amp);
                            r_is_tick     <= 1'b1;
                            r_state       <= S_ROM;
                        end
                    end
                end
                S_STEP_DIV: begin
                    if (r_cnt == '0) begin
                        // a zero rate gives a zero step
                        r_phase_inc <= (r_dvs == '0) ? '0 : n_div_work[PHASE_BITS-1:0];
                        r_work      <= '0;
                        r_cnt       <= MUL_LAST;
                        r_state     <= S_MUL;
                    end else begin
                        r_work <= n_div_work;
                        r_rem  <= n_rem;
                        r_cnt  <= r_cnt - 1'b1;
                    end
                end
                S_ROM: begin
                    r_work  <= '0;
                    r_cnt   <= MUL_LAST;
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    r_work <= n_mul_work;
                    r_mplr <= {r_mplr[tstg_pkg::DUR_W-2:0], 1'b0};
                    if (r_cnt == '0) begin
                        if (r_is_tick) begin
                            r_res_fv  <= 1'b1;
                            r_res_pcm <= n_pcm;
                            r_state   <= S_EMIT;
                        end else begin
                            r_rem   <= '0;
                            r_dvs   <= tstg_pkg::MS_PER_S;
                            r_cnt   <= DIV_LAST;
                            r_state <= S_FDIV;
                        end
                    end else begin
                        r_cnt <= r_cnt - 1'b1;
                    end
                end
                S_FDIV: begin
                    r_work <= n_div_work;
                    r_rem  <= n_rem;
                    r_cnt  <= r_cnt - 1'b1;
                    if (r_cnt == '0) begin
                        r_frames_left <= n_frames;
                        r_res_acc     <= 1'b1;
                        r_state       <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (w_slot_free) begin
                        r_o_valid <= 1'b1;
                        r_o_acc   <= r_res_acc;
                        r_o_fv    <= r_res_fv;
                        r_o_pcm   <= r_res_pcm;
                        r_o_last  <= r_res_last;
                        r_state   <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign i_req.ready          = (r_state == S_IDLE);
    assign o_rsp.valid          = r_o_valid;
    assign o_rsp.start_accepted = r_o_acc;
    assign o_rsp.frame_valid    = r_o_fv;
    assign o_rsp.pcm_sample     = r_o_pcm;
    assign o_rsp.last_frame     = r_o_last;

    a_amp_clamped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_amp <= tstg_pkg::AMP_LIMIT)
        else $error("active amplitude above clamp limit");

    a_tick_counts_down: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_req.mode == tstg_pkg::MODE_TICK && r_frames_left != '0) |=>
        (r_frames_left == $past(r_frames_left) - 24'd1))
        else $error("frame count not decremented on tick");

    a_frames_hold_when_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_STEP_DIV || r_state == S_MUL || r_state == S_ROM) |=>
        $stable(r_frames_left))
        else $error("frame count changed mid request");

    a_result_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_valid |-> !(r_o_acc && r_o_fv))
        else $error("result is both start status and frame");

    a_idle_output_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && !r_o_fv) |-> (r_o_pcm == '0 && !r_o_last))
        else $error("non-frame result carries sample data");
endmodule
